@@ sv/pvpt_pkg.sv @@
package pvpt_pkg;

  // Position width, and the number of CORDIC rotations (at most 32 are used).
  localparam int POS_BITS     = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // Displacement and speed widths.
  localparam int VEL_W = POS_BITS + 1;
  localparam int RW    = VEL_W;
  localparam int SQ_W  = 2 * POS_BITS;
  localparam int NW    = 2 * RW;
  localparam int REMW  = RW + 3;

  // One cell produces one bit of the square root.
  localparam int SQRT_STEPS = RW;

  // CORDIC datapath: components are scaled by 2^14 and grow by the CORDIC gain.
  localparam int FRAC_SHIFT = 14;
  localparam int CW         = POS_BITS + 17;
  localparam int ZW         = 34;
  localparam int HEAD_W     = 16;

  localparam int N_CELLS = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;
  localparam int IDX_W   = ($clog2(N_CELLS + 1) > 5) ? $clog2(N_CELLS + 1) : 5;

  localparam logic [ZW-1:0]     Z_PI       = ZW'(64'h8000_0000);
  localparam logic [ZW-1:0]     Z_NEG_PI   = ZW'(-64'sh8000_0000);
  localparam logic [ZW-1:0]     Z_ROUND    = ZW'(64'h8000);
  localparam logic [HEAD_W-1:0] HEAD_ZERO  = '0;
  localparam logic [HEAD_W-1:0] HEAD_PI    = HEAD_W'(32'h8000);

  typedef struct packed {
    logic [VEL_W-1:0] dx;
    logic [VEL_W-1:0] dy;
    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    logic [ZW-1:0]    cz;
    logic [NW-1:0]    nrad;
    logic [RW-1:0]    root;
    logic [REMW-1:0]  remd;
  } cell_data_t;

  // Arctangent of 2^-i in units where 2^31 stands for pi.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ sv/position_velocity_polar_tracker.sv @@
// Position to velocity and polar form tracker. Each request carries a new 2-D position
// in signed Q2.14 metres; the block subtracts the previous position (the origin after
// reset) and returns the displacement components, the speed rounded to nearest, and the
// heading atan2(vel_y, vel_x) as a 16-bit binary angle where 32768 stands for pi. The
// work runs in a pipeline: three front stages (difference, squares and CORDIC setup,
// sum of squares) feed a row of seventeen identical cells, each of which produces one
// bit of the square root, with the first sixteen also doing one CORDIC rotation each.
// A last stage rounds and forms the heading into the output register. A request can be
// accepted in every cycle while in_stall is low. Its result moves through the three front
// stages, the seventeen cells and the output register, where it can be taken. When the
// output register holds a result that is stalled, the whole pipeline freezes and
// in_stall is raised until the result is taken.
module position_velocity_polar_tracker import pvpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [POS_BITS-1:0] in_pos_x,
  input  logic [POS_BITS-1:0] in_pos_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VEL_W-1:0]    out_vel_x,
  output logic [VEL_W-1:0]    out_vel_y,
  output logic [RW-1:0]       out_speed,
  output logic [HEAD_W-1:0]   out_heading
);

  // The pipeline moves as one piece whenever the output register can take a result.
  logic adv;

  logic       link_vld  [N_CELLS+1];
  cell_data_t link_data [N_CELLS+1];

  logic                out_valid_r;
  logic [VEL_W-1:0]    vel_x_r, vel_y_r;
  logic [RW-1:0]       speed_r;
  logic [HEAD_W-1:0]   heading_r;

  cell_data_t          fin;
  logic                round_up;
  logic [RW-1:0]       speed_nxt;
  logic [ZW-1:0]       z_rnd;
  logic [HEAD_W-1:0]   heading_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  pvpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_pos_x (in_pos_x),
    .in_pos_y (in_pos_y),
    .out_vld  (link_vld[0]),
    .out_data (link_data[0])
  );

  // The row of cells; cell i holds square-root digit i and, for i below CORDIC_N, CORDIC rotation i.
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    pvpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(i)),
      .in_vld   (link_vld[i]),
      .in_data  (link_data[i]),
      .out_vld  (link_vld[i+1]),
      .out_data (link_data[i+1])
    );
  end

  // The root digit loop leaves remd = N - r*r, so rounding up is needed exactly when
  // remd exceeds r. The heading rounds the 2^31-per-pi accumulator to 16 bits; a zero
  // vertical displacement is taken straight from the sign of the horizontal one.
  always_comb begin
    fin       = link_data[N_CELLS];
    round_up  = fin.remd > REMW'(fin.root);
    speed_nxt = fin.root + RW'(round_up);
    z_rnd     = fin.cz + Z_ROUND;
    if (fin.dy == '0) begin
      heading_nxt = fin.dx[VEL_W-1] ? HEAD_PI : HEAD_ZERO;
    end else begin
      heading_nxt = z_rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= link_vld[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && link_vld[N_CELLS]) begin
      vel_x_r   <= fin.dx;
      vel_y_r   <= fin.dy;
      speed_r   <= speed_nxt;
      heading_r <= heading_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_vel_x   = vel_x_r;
  assign out_vel_y   = vel_y_r;
  assign out_speed   = speed_r;
  assign out_heading = heading_r;

  // A result leaving the last cell lands in the output register.
  a_chain_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    link_vld[N_CELLS] && adv |=> out_valid_r)
    else $error("result from the cell row was lost");

  // A still object reports zero speed and zero heading.
  a_zero_vector : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_vel_x == '0) && (out_vel_y == '0)
      |-> (out_speed == '0) && (out_heading == HEAD_ZERO))
    else $error("zero displacement gave nonzero speed or heading");

  // Straight backward motion points at -pi.
  a_backward : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_vel_y == '0) && out_vel_x[VEL_W-1] |-> (out_heading == HEAD_PI))
    else $error("backward motion heading is not -pi");

  // The speed is never below the horizontal component's magnitude.
  a_speed_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (VEL_W'(out_speed) >=
      (out_vel_x[VEL_W-1] ? VEL_W'(-out_vel_x) : out_vel_x)))
    else $error("speed below horizontal displacement");

endmodule

@@ sv/pvpt_front.sv @@
module pvpt_front import pvpt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [POS_BITS-1:0] in_pos_x,
  input  logic [POS_BITS-1:0] in_pos_y,
  output logic                out_vld,
  output cell_data_t          out_data
);

  logic [POS_BITS-1:0] last_x_r, last_y_r;
  logic [VEL_W-1:0]    dx_nxt, dy_nxt;

  logic                a_vld_r;
  logic [VEL_W-1:0]    a_dx_r, a_dy_r;

  logic                b_vld_r;
  logic [VEL_W-1:0]    b_dx_r, b_dy_r;
  logic [SQ_W-1:0]     b_sqx_r, b_sqy_r;
  logic [CW-1:0]       b_cx_r, b_cy_r;
  logic [ZW-1:0]       b_cz_r;

  logic                c_vld_r;
  cell_data_t          c_data_r;

  logic [VEL_W-1:0]        mag_x, mag_y;
  logic signed [CW-1:0]    dxe, dye, x0, y0;
  logic                    neg;
  logic [ZW-1:0]           z0;

  assign dx_nxt = {in_pos_x[POS_BITS-1], in_pos_x} - {last_x_r[POS_BITS-1], last_x_r};
  assign dy_nxt = {in_pos_y[POS_BITS-1], in_pos_y} - {last_y_r[POS_BITS-1], last_y_r};

  always_comb begin
    mag_x = a_dx_r[VEL_W-1] ? -a_dx_r : a_dx_r;
    mag_y = a_dy_r[VEL_W-1] ? -a_dy_r : a_dy_r;
    neg   = a_dx_r[VEL_W-1];
    dxe   = CW'($signed(a_dx_r));
    dye   = CW'($signed(a_dy_r));
    x0    = (neg ? -dxe : dxe) <<< FRAC_SHIFT;
    y0    = (neg ? -dye : dye) <<< FRAC_SHIFT;
    if (!neg) begin
      z0 = '0;
    end else if (!a_dy_r[VEL_W-1] && (a_dy_r != '0)) begin
      z0 = Z_PI;
    end else begin
      z0 = Z_NEG_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
    end else if (adv) begin
      if (in_valid) begin
        last_x_r <= in_pos_x;
        last_y_r <= in_pos_y;
      end
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r  <= dx_nxt;
      a_dy_r  <= dy_nxt;
      b_dx_r  <= a_dx_r;
      b_dy_r  <= a_dy_r;
      b_sqx_r <= mag_x[POS_BITS-1:0] * mag_x[POS_BITS-1:0];
      b_sqy_r <= mag_y[POS_BITS-1:0] * mag_y[POS_BITS-1:0];
      b_cx_r  <= x0;
      b_cy_r  <= y0;
      b_cz_r  <= z0;
      c_data_r.dx   <= b_dx_r;
      c_data_r.dy   <= b_dy_r;
      c_data_r.cx   <= b_cx_r;
      c_data_r.cy   <= b_cy_r;
      c_data_r.cz   <= b_cz_r;
      c_data_r.nrad <= NW'(b_sqx_r) + NW'(b_sqy_r);
      c_data_r.root <= '0;
      c_data_r.remd <= '0;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_data = c_data_r;

endmodule

@@ sv/pvpt_cell.sv @@
module pvpt_cell import pvpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             in_vld,
  input  cell_data_t       in_data,
  output logic             out_vld,
  output cell_data_t       out_data
);

  logic                 vld_r;
  cell_data_t           data_r, data_nxt;
  logic signed [CW-1:0] x_in, y_in, xs, ys;
  logic [ZW-1:0]        ang;
  logic [REMW-1:0]      rem_sh, trial;

  // Each cell does one square-root digit and, when cell_idx is below CORDIC_N, one CORDIC vectoring rotation.
  always_comb begin
    data_nxt = in_data;
    x_in     = $signed(in_data.cx);
    y_in     = $signed(in_data.cy);
    xs       = x_in >>> cell_idx;
    ys       = y_in >>> cell_idx;
    ang      = ZW'(atan_entry(cell_idx[4:0]));
    rem_sh   = {in_data.remd[REMW-3:0], in_data.nrad[NW-1 -: 2]};
    trial    = REMW'({in_data.root, 2'b01});

    if (int'(cell_idx) < CORDIC_N) begin
      if (!in_data.cy[CW-1]) begin
        data_nxt.cx = x_in + ys;
        data_nxt.cy = y_in - xs;
        data_nxt.cz = in_data.cz + ang;
      end else begin
        data_nxt.cx = x_in - ys;
        data_nxt.cy = y_in + xs;
        data_nxt.cz = in_data.cz - ang;
      end
    end

    if (int'(cell_idx) < SQRT_STEPS) begin
      data_nxt.nrad = {in_data.nrad[NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        data_nxt.remd = rem_sh - trial;
        data_nxt.root = {in_data.root[RW-2:0], 1'b1};
      end else begin
        data_nxt.remd = rem_sh;
        data_nxt.root = {in_data.root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule
